>>> rtl/ufe_pkg.sv
// Shared types and constants for the union-find engine.
// No dependencies; imported by ufe_ctrl, ufe_datapath and union_find_engine_core.
`default_nettype none

package ufe_pkg;

   localparam int RANK_W = 4;
   localparam int SIZE_W = 9;
   localparam int ROOT_W = 8;

   localparam logic [RANK_W-1:0] RANK_INIT = 4'd0;
   localparam logic [RANK_W-1:0] RANK_MAX  = 4'd15;
   localparam logic [SIZE_W-1:0] SIZE_INIT = 9'd1;
   localparam logic [SIZE_W-1:0] SIZE_MAX  = 9'd511;

   // request command codes
   localparam logic CMD_FIND  = 1'b0;
   localparam logic CMD_UNION = 1'b1;

   // union_mode register codes
   localparam logic MODE_RANK = 1'b0;
   localparam logic MODE_SIZE = 1'b1;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_FIND_RD,
      ST_FIND_CHK,
      ST_COMP_CHK,
      ST_COMP_WR,
      ST_META_A,
      ST_META_B,
      ST_LINK,
      ST_DONE
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic sweep_step;
      logic load_req;
      logic par_rd;
      logic find_adv;
      logic find_root;
      logic comp_wr;
      logic next_side;
      logic meta_rd;
      logic meta_sel_b;
      logic meta_cap_a;
      logic link;
      logic out_load;
   } ctrl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic rd_is_self;
      logic cur_is_root;
      logic sweep_last;
      logic side;
      logic link_needed;
      logic out_free;
   } dp_stat_type;

endpackage

`default_nettype wire

>>> rtl/ufe_ctrl.sv
// Sequencer of the union-find engine: root walks, compression, linking.
// Depends on ufe_pkg; drives ufe_datapath through ctrl_cmd_type.
`default_nettype none

module ufe_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  ufe_pkg::dp_stat_type   dp_stat,
   output ufe_pkg::ctrl_cmd_type  ctrl_cmd
);
   import ufe_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (dp_stat.sweep_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) state_in = ST_FIND_RD;
         end
         ST_FIND_RD: begin
            state_in = ST_FIND_CHK;
         end
         ST_FIND_CHK: begin
            state_in = dp_stat.rd_is_self ? ST_COMP_CHK : ST_FIND_RD;
         end
         ST_COMP_CHK: begin
            if (!dp_stat.cur_is_root) begin
               state_in = ST_COMP_WR;
            end else if (!dp_stat.side) begin
               state_in = ST_FIND_RD;
            end else if (dp_stat.link_needed) begin
               state_in = ST_META_A;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_COMP_WR: begin
            state_in = ST_COMP_CHK;
         end
         ST_META_A: begin
            state_in = ST_META_B;
         end
         ST_META_B: begin
            state_in = ST_LINK;
         end
         ST_LINK: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (dp_stat.out_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      ctrl_cmd  = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            ctrl_cmd.sweep_step = 1'b1;
         end
         ST_IDLE: begin
            req_ready         = 1'b1;
            ctrl_cmd.load_req = req_valid;
         end
         ST_FIND_RD: begin
            ctrl_cmd.par_rd = 1'b1;
         end
         ST_FIND_CHK: begin
            if (dp_stat.rd_is_self) begin
               ctrl_cmd.find_root = 1'b1;
            end else begin
               ctrl_cmd.find_adv = 1'b1;
            end
         end
         ST_COMP_CHK: begin
            if (!dp_stat.cur_is_root) begin
               ctrl_cmd.par_rd = 1'b1;
            end else if (!dp_stat.side) begin
               ctrl_cmd.next_side = 1'b1;
            end
         end
         ST_COMP_WR: begin
            ctrl_cmd.comp_wr = 1'b1;
         end
         ST_META_A: begin
            ctrl_cmd.meta_rd = 1'b1;
         end
         ST_META_B: begin
            ctrl_cmd.meta_rd    = 1'b1;
            ctrl_cmd.meta_sel_b = 1'b1;
            ctrl_cmd.meta_cap_a = 1'b1;
         end
         ST_LINK: begin
            ctrl_cmd.link = 1'b1;
         end
         ST_DONE: begin
            ctrl_cmd.out_load = dp_stat.out_free;
         end
         default: begin
            ctrl_cmd = '0;
         end
      endcase
   end

endmodule

`default_nettype wire

>>> rtl/ufe_datapath.sv
// Datapath of the union-find engine: parent, rank and size stores, walk
// registers, link logic and the response register. Depends on ufe_pkg.
`default_nettype none

module ufe_datapath #(
   parameter int NODES = 256
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_cmd,
   input  logic [7:0]                      req_node_a,
   input  logic [7:0]                      req_node_b,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [ufe_pkg::ROOT_W-1:0]      rsp_root_a,
   output logic [ufe_pkg::ROOT_W-1:0]      rsp_root_b,
   output logic                            rsp_same_set,
   output logic                            rsp_merged,
   input  logic                            csr_wr_en,
   input  logic                            csr_wr_data,
   input  ufe_pkg::ctrl_cmd_type           ctrl_cmd,
   output ufe_pkg::dp_stat_type            dp_stat
);
   import ufe_pkg::*;

   localparam int NODE_W = $clog2(NODES);
   localparam int RED_W  = NODE_W + 9;
   localparam logic [RED_W-1:0]  NODES_EXT = RED_W'(NODES);
   localparam logic [NODE_W-1:0] LAST_NODE = NODE_W'(NODES - 1);

   // reduce an 8-bit index modulo NODES by restoring subtraction
   function automatic logic [NODE_W-1:0] reduce_node(input logic [7:0] v);
      logic [RED_W-1:0] r;
      r = RED_W'(v);
      for (int k = 7; k >= 0; k--) begin
         if (r >= (NODES_EXT << k)) r = r - (NODES_EXT << k);
      end
      return r[NODE_W-1:0];
   endfunction

   logic [NODE_W-1:0] parent_mem [NODES];
   logic [RANK_W-1:0] rank_mem   [NODES];
   logic [SIZE_W-1:0] size_mem   [NODES];

   logic              cmd_ff;
   logic [NODE_W-1:0] node_a_ff, node_b_ff;
   logic [NODE_W-1:0] cur_ff, cur_in;
   logic              side_ff, side_in;
   logic [NODE_W-1:0] root_a_ff, root_a_in;
   logic [NODE_W-1:0] root_b_ff, root_b_in;
   logic [NODE_W-1:0] parent_rd_ff;
   logic [RANK_W-1:0] rank_rd_ff, rank_a_ff;
   logic [SIZE_W-1:0] size_rd_ff, size_a_ff;
   logic              union_mode_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [ROOT_W-1:0] rsp_root_a_ff, rsp_root_b_ff;
   logic              rsp_same_ff, rsp_merged_ff;

   logic [NODE_W-1:0] root_side;
   logic [NODE_W-1:0] meta_addr;
   logic              link_needed;
   logic              rank_a_gt, rank_b_gt, size_a_lt;
   logic [SIZE_W:0]   size_sum;
   logic [SIZE_W-1:0] size_sat;
   logic [NODE_W-1:0] link_child, link_head;
   logic [ROOT_W+NODE_W-1:0] root_a_ext, root_b_ext;

   logic              par_we;
   logic [NODE_W-1:0] par_waddr, par_wdata;
   logic              rank_we;
   logic [NODE_W-1:0] rank_waddr;
   logic [RANK_W-1:0] rank_wdata;
   logic              size_we;
   logic [NODE_W-1:0] size_waddr;
   logic [SIZE_W-1:0] size_wdata;

   assign root_side   = side_ff ? root_b_ff : root_a_ff;
   assign meta_addr   = ctrl_cmd.meta_sel_b ? root_b_ff : root_a_ff;
   assign link_needed = (cmd_ff == CMD_UNION) && (root_a_ff != root_b_ff);

   // link decision; rank/size of root_a captured, root_b in the read register
   assign rank_a_gt = rank_a_ff > rank_rd_ff;
   assign rank_b_gt = rank_rd_ff > rank_a_ff;
   assign size_a_lt = size_a_ff < size_rd_ff;
   assign size_sum  = {1'b0, size_a_ff} + {1'b0, size_rd_ff};
   assign size_sat  = (size_sum > {1'b0, SIZE_MAX}) ? SIZE_MAX : size_sum[SIZE_W-1:0];

   always_comb begin
      if (union_mode_ff == MODE_SIZE) begin
         link_child = size_a_lt ? root_a_ff : root_b_ff;
         link_head  = size_a_lt ? root_b_ff : root_a_ff;
      end else begin
         link_child = rank_a_gt ? root_b_ff : root_a_ff;
         link_head  = rank_a_gt ? root_a_ff : root_b_ff;
      end
   end

   // store write ports
   always_comb begin
      par_we    = 1'b0;
      par_waddr = cur_ff;
      par_wdata = cur_ff;
      if (ctrl_cmd.sweep_step) begin
         par_we = 1'b1;
      end else if (ctrl_cmd.comp_wr) begin
         par_we    = 1'b1;
         par_wdata = root_side;
      end else if (ctrl_cmd.link) begin
         par_we    = 1'b1;
         par_waddr = link_child;
         par_wdata = link_head;
      end
   end

   always_comb begin
      rank_we    = 1'b0;
      rank_waddr = cur_ff;
      rank_wdata = RANK_INIT;
      size_we    = 1'b0;
      size_waddr = cur_ff;
      size_wdata = SIZE_INIT;
      if (ctrl_cmd.sweep_step) begin
         rank_we = 1'b1;
         size_we = 1'b1;
      end else if (ctrl_cmd.link) begin
         // tie under rank: root_b becomes head and gains one rank unless at RANK_MAX
         rank_we    = (union_mode_ff == MODE_RANK) && !rank_a_gt && !rank_b_gt &&
                      (rank_rd_ff != RANK_MAX);
         rank_waddr = root_b_ff;
         rank_wdata = rank_rd_ff + 1'b1;
         size_we    = (union_mode_ff == MODE_SIZE);
         size_waddr = link_head;
         size_wdata = size_sat;
      end
   end

   always_ff @(posedge clock) begin
      if (par_we) parent_mem[par_waddr] <= par_wdata;
      if (ctrl_cmd.par_rd) parent_rd_ff <= parent_mem[cur_ff];
      if (rank_we) rank_mem[rank_waddr] <= rank_wdata;
      if (size_we) size_mem[size_waddr] <= size_wdata;
      if (ctrl_cmd.meta_rd) begin
         rank_rd_ff <= rank_mem[meta_addr];
         size_rd_ff <= size_mem[meta_addr];
      end
   end

   // walk registers
   always_comb begin
      cur_in    = cur_ff;
      side_in   = side_ff;
      root_a_in = root_a_ff;
      root_b_in = root_b_ff;
      if (ctrl_cmd.sweep_step) begin
         cur_in = cur_ff + 1'b1;
      end
      if (ctrl_cmd.load_req) begin
         cur_in  = reduce_node(req_node_a);
         side_in = 1'b0;
      end
      if (ctrl_cmd.find_adv || ctrl_cmd.comp_wr) begin
         cur_in = parent_rd_ff;
      end
      if (ctrl_cmd.find_root) begin
         cur_in = side_ff ? node_b_ff : node_a_ff;
         if (side_ff) begin
            root_b_in = cur_ff;
         end else begin
            root_a_in = cur_ff;
         end
      end
      if (ctrl_cmd.next_side) begin
         cur_in  = node_b_ff;
         side_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff        <= '0;
         side_ff       <= 1'b0;
         union_mode_ff <= MODE_RANK;
         rsp_valid_ff  <= 1'b0;
      end else begin
         cur_ff       <= cur_in;
         side_ff      <= side_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) union_mode_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      root_a_ff <= root_a_in;
      root_b_ff <= root_b_in;
      if (ctrl_cmd.load_req) begin
         cmd_ff    <= req_cmd;
         node_a_ff <= reduce_node(req_node_a);
         node_b_ff <= reduce_node(req_node_b);
      end
      if (ctrl_cmd.meta_cap_a) begin
         rank_a_ff <= rank_rd_ff;
         size_a_ff <= size_rd_ff;
      end
   end

   // response register
   assign root_a_ext   = {{ROOT_W{1'b0}}, root_a_ff};
   assign root_b_ext   = {{ROOT_W{1'b0}}, root_b_ff};
   assign rsp_valid_in = ctrl_cmd.out_load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (ctrl_cmd.out_load) begin
         rsp_root_a_ff <= root_a_ext[ROOT_W-1:0];
         rsp_root_b_ff <= root_b_ext[ROOT_W-1:0];
         rsp_same_ff   <= (root_a_ff == root_b_ff);
         rsp_merged_ff <= link_needed;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_root_a   = rsp_root_a_ff;
   assign rsp_root_b   = rsp_root_b_ff;
   assign rsp_same_set = rsp_same_ff;
   assign rsp_merged   = rsp_merged_ff;

   assign dp_stat.rd_is_self  = (parent_rd_ff == cur_ff);
   assign dp_stat.cur_is_root = (cur_ff == root_side);
   assign dp_stat.sweep_last  = (cur_ff == LAST_NODE);
   assign dp_stat.side        = side_ff;
   assign dp_stat.link_needed = link_needed;
   assign dp_stat.out_free    = !rsp_valid_ff || rsp_ready;

endmodule

`default_nettype wire

>>> rtl/union_find_engine_core.sv
// Top level of the union-find engine: controller plus datapath.
// Depends on ufe_pkg, ufe_ctrl and ufe_datapath.
`default_nettype none

// Channel   Direction  Handshake              Payload
// req       in         req_valid/req_ready    req_cmd, req_node_a, req_node_b
// rsp       out        rsp_valid/rsp_ready    rsp_root_a, rsp_root_b, rsp_same_set, rsp_merged
// csr       in         csr_wr_en (no wait)    csr_wr_data (union_mode)
//
// Sequencing: one request at a time. Each parent link walked costs a read
//    and a check on the parent store's single read port, and compression
//    costs a read and a write per node; when a union links two roots, the
//    two metadata reads (ST_META_A, ST_META_B) and the link write (ST_LINK)
//    follow before the response is loaded.
// Reset: the stores are swept after reset, one entry a cycle, with
//    req_ready low; csr writes are taken throughout.
// Stalls: a finished response sits in an output register; the next request
//    is taken while it waits, and the engine holds only before loading the
//    following response.

module union_find_engine_core #(
   parameter int NODES = 256
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic                        req_cmd,
   input  logic [7:0]                  req_node_a,
   input  logic [7:0]                  req_node_b,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [ufe_pkg::ROOT_W-1:0]  rsp_root_a,
   output logic [ufe_pkg::ROOT_W-1:0]  rsp_root_b,
   output logic                        rsp_same_set,
   output logic                        rsp_merged,
   input  logic                        csr_wr_en,
   input  logic                        csr_wr_data
);
   import ufe_pkg::*;

   ctrl_cmd_type ctrl_cmd;
   dp_stat_type  dp_stat;

   // sequencer: walk, compress, link, respond
   ufe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .dp_stat   (dp_stat),
      .ctrl_cmd  (ctrl_cmd)
   );

   // stores, walk registers and response register
   ufe_datapath #(
      .NODES (NODES)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .req_cmd      (req_cmd),
      .req_node_a   (req_node_a),
      .req_node_b   (req_node_b),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_root_a   (rsp_root_a),
      .rsp_root_b   (rsp_root_b),
      .rsp_same_set (rsp_same_set),
      .rsp_merged   (rsp_merged),
      .csr_wr_en    (csr_wr_en),
      .csr_wr_data  (csr_wr_data),
      .ctrl_cmd     (ctrl_cmd),
      .dp_stat      (dp_stat)
   );

endmodule

`default_nettype wire
